>>> rtl/core/debounced_dirty_set_flusher_assert.svh
// Assertion macros for the debounced dirty set flusher.
// Included by the RTL files that carry concurrent checks; needs no package.
`ifndef DEBOUNCED_DIRTY_SET_FLUSHER_ASSERT_SVH
`define DEBOUNCED_DIRTY_SET_FLUSHER_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define DDSF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ddsf: same-cycle check failed");
// Next-cycle implication, disabled while reset is asserted.
`define DDSF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ddsf: next-cycle check failed");
`else
`define DDSF_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define DDSF_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/core/ddsf_pkg.sv
// Shared constants for the debounced dirty set flusher.
// Used by the top level; has no dependencies of its own.
package ddsf_pkg;

    localparam int LIST_DEPTH = 16;
    localparam int ID_WIDTH   = 8;
    localparam int IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
    localparam int DELAY_W    = 16;
    localparam int ACT_W      = 2;

    localparam logic [DELAY_W-1:0] DELAY_RESET = DELAY_W'(150);

    localparam logic [ACT_W-1:0] ACT_TICK   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_MARK   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_FORGET = 2'd2;

    localparam logic [ID_WIDTH-1:0] ID_NULL = '0;

endpackage

>>> rtl/core/debounced_dirty_set_flusher.sv
// Top level of the debounced dirty set flusher: sequencer, list bookkeeping, countdown.
// Depends on ddsf_pkg, ddsf_ram and debounced_dirty_set_flusher_assert.svh.
//
//  channel | ports                                   | direction | word
//  --------+-----------------------------------------+-----------+------------------------
//  s_      | s_valid/s_ready, s_action, s_client_id  | in        | one event
//  m_      | m_valid/m_ready, m_synced_*, m_last ... | out       | one result per word
//  cfg_    | cfg_valid/cfg_ready, cfg_delay_ticks    | in        | new debounce delay
//
// An event takes work proportional to the list length N: the search reads one RAM
// entry per cycle, a forget moves each later entry down with a read and a write, and
// a flush reads each id back and emits it as a result word, stalling on m_ready.
// All list reads go through the single read port of the RAM, which sets the pace.
// Reset is synchronous and active low; the list RAM is not cleared, since only entries
// below the pending count are ever read. s_ready is high only while idle, even if the
// last result word still waits on m_ready; a stalled m_ready holds the sequencer.
module debounced_dirty_set_flusher
    import ddsf_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                s_valid,
    output logic                s_ready,
    input  logic [ACT_W-1:0]    s_action,
    input  logic [ID_WIDTH-1:0] s_client_id,

    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_synced_valid,
    output logic [ID_WIDTH-1:0] m_synced_id,
    output logic                m_last,
    output logic                m_is_pending,
    output logic [CNT_W-1:0]    m_pending_count,
    output logic                m_overflow,

    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [DELAY_W-1:0]  cfg_delay_ticks
);

`include "debounced_dirty_set_flusher_assert.svh"

    // Sequencer states.
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SEARCH = 3'd1;
    localparam logic [2:0] ST_APPLY  = 3'd2;
    localparam logic [2:0] ST_SH_RD  = 3'd3;
    localparam logic [2:0] ST_SH_WR  = 3'd4;
    localparam logic [2:0] ST_STATUS = 3'd5;
    localparam logic [2:0] ST_FL_RD  = 3'd6;
    localparam logic [2:0] ST_FL_LD  = 3'd7;

    // Control state.
    logic [2:0]          state_reg,   state_next;
    logic [CNT_W-1:0]    total_reg,   total_next;
    logic [DELAY_W-1:0]  cd_reg,      cd_next;
    logic                run_reg,     run_next;
    logic [DELAY_W-1:0]  delay_reg,   delay_next;
    logic                cmp_vld_reg, cmp_vld_next;
    logic                m_valid_reg, m_valid_next;

    // Per-event working registers.
    logic [ACT_W-1:0]    act_reg,     act_next;
    logic [ID_WIDTH-1:0] id_reg,      id_next;
    logic [CNT_W-1:0]    idx_reg,     idx_next;
    logic [CNT_W-1:0]    flush_n_reg, flush_n_next;
    logic                found_reg,   found_next;
    logic                ovf_reg,     ovf_next;
    logic                pend_reg,    pend_next;

    // Result word register.
    logic                sv_reg,      sv_next;
    logic [ID_WIDTH-1:0] sid_reg,     sid_next;
    logic                last_reg,    last_next;
    logic                opend_reg,   opend_next;
    logic [CNT_W-1:0]    ocnt_reg,    ocnt_next;
    logic                oovf_reg,    oovf_next;

    // List RAM ports.
    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    logic [ID_WIDTH-1:0] ram_wdata;
    logic                ram_re;
    logic [IDX_W-1:0]    ram_raddr;
    logic [ID_WIDTH-1:0] ram_rdata;

    logic                out_free;
    logic                issue_ok;
    logic                hit;
    logic                do_flush;
    logic                forget_fin;
    logic                append;
    logic [CNT_W-1:0]    idx_inc;
    logic [CNT_W-1:0]    idx_inc2;

    ddsf_ram #(
        .DATA_W (ID_WIDTH),
        .DEPTH  (LIST_DEPTH)
    ) u_list_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    // The result register can take a new word when empty or when its word leaves now.
    assign out_free = !m_valid_reg || m_ready;
    // The search issues a read while unread entries remain and compares the returned entry in the following cycle.
    assign issue_ok = (idx_reg < total_reg);
    assign hit      = cmp_vld_reg && (ram_rdata == id_reg);
    assign idx_inc  = idx_reg + CNT_W'(1);
    assign idx_inc2 = idx_reg + CNT_W'(2);
    assign append   = (act_reg == ACT_MARK) && (id_reg != ID_NULL) && !found_reg
                      && (total_reg < CNT_W'(LIST_DEPTH));

    always_comb begin
        state_next   = state_reg;
        total_next   = total_reg;
        cd_next      = cd_reg;
        run_next     = run_reg;
        delay_next   = delay_reg;
        cmp_vld_next = cmp_vld_reg;
        m_valid_next = m_valid_reg;
        act_next     = act_reg;
        id_next      = id_reg;
        idx_next     = idx_reg;
        flush_n_next = flush_n_reg;
        found_next   = found_reg;
        ovf_next     = ovf_reg;
        pend_next    = pend_reg;
        sv_next      = sv_reg;
        sid_next     = sid_reg;
        last_next    = last_reg;
        opend_next   = opend_reg;
        ocnt_next    = ocnt_reg;
        oovf_next    = oovf_reg;

        ram_we     = 1'b0;
        ram_waddr  = total_reg[IDX_W-1:0];
        ram_wdata  = id_reg;
        ram_re     = 1'b0;
        ram_raddr  = idx_reg[IDX_W-1:0];
        do_flush   = 1'b0;
        forget_fin = 1'b0;

        if (cfg_valid) begin
            delay_next = cfg_delay_ticks;
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    act_next     = s_action;
                    id_next      = s_client_id;
                    idx_next     = '0;
                    cmp_vld_next = 1'b0;
                    found_next   = 1'b0;
                    ovf_next     = 1'b0;
                    // The null id and an empty list need no search.
                    if (s_client_id != ID_NULL && total_reg != '0) begin
                        state_next = ST_SEARCH;
                    end else begin
                        state_next = ST_APPLY;
                    end
                end
            end

            ST_SEARCH: begin
                ram_re       = issue_ok;
                cmp_vld_next = issue_ok;
                if (issue_ok) begin
                    idx_next = idx_inc;
                end
                if (hit) begin
                    // The matching entry was read in the previous cycle.
                    found_next = 1'b1;
                    idx_next   = idx_reg - CNT_W'(1);
                    state_next = ST_APPLY;
                end else if (!issue_ok) begin
                    state_next = ST_APPLY;
                end
            end

            ST_APPLY: begin
                state_next = ST_STATUS;
                pend_next  = found_reg;
                if (act_reg == ACT_MARK && id_reg != ID_NULL) begin
                    if (append) begin
                        ram_we     = 1'b1;
                        total_next = total_reg + CNT_W'(1);
                    end else if (!found_reg) begin
                        ovf_next = 1'b1;
                    end
                    pend_next = found_reg || append;
                    if (delay_reg == '0) begin
                        do_flush = 1'b1;
                    end else begin
                        cd_next  = delay_reg;
                        run_next = 1'b1;
                    end
                end else if (act_reg == ACT_FORGET && id_reg != ID_NULL) begin
                    pend_next = 1'b0;
                    if (found_reg) begin
                        if (idx_inc < total_reg) begin
                            state_next = ST_SH_RD;
                        end else begin
                            forget_fin = 1'b1;
                        end
                    end else if (total_reg == '0) begin
                        run_next = 1'b0;
                        cd_next  = '0;
                    end
                end else if (act_reg == ACT_TICK && run_reg) begin
                    if (cd_reg <= DELAY_W'(1)) begin
                        do_flush = 1'b1;
                    end else begin
                        cd_next = cd_reg - DELAY_W'(1);
                    end
                end
            end

            ST_SH_RD: begin
                ram_re     = 1'b1;
                ram_raddr  = idx_inc[IDX_W-1:0];
                state_next = ST_SH_WR;
            end

            ST_SH_WR: begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg[IDX_W-1:0];
                ram_wdata = ram_rdata;
                idx_next  = idx_inc;
                if (idx_inc2 < total_reg) begin
                    state_next = ST_SH_RD;
                end else begin
                    forget_fin = 1'b1;
                end
            end

            ST_STATUS: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    sv_next      = 1'b0;
                    sid_next     = ID_NULL;
                    last_next    = 1'b1;
                    opend_next   = pend_reg;
                    ocnt_next    = total_reg;
                    oovf_next    = ovf_reg;
                    state_next   = ST_IDLE;
                end
            end

            ST_FL_RD: begin
                ram_re     = 1'b1;
                state_next = ST_FL_LD;
            end

            ST_FL_LD: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    sv_next      = 1'b1;
                    sid_next     = ram_rdata;
                    last_next    = (idx_inc == flush_n_reg);
                    opend_next   = pend_reg;
                    ocnt_next    = total_reg;
                    oovf_next    = ovf_reg;
                    idx_next     = idx_inc;
                    state_next   = (idx_inc == flush_n_reg) ? ST_IDLE : ST_FL_RD;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // A flush empties the list and stops the countdown; the ids are read back
        // from the RAM one at a time afterwards.
        if (do_flush) begin
            run_next     = 1'b0;
            cd_next      = '0;
            pend_next    = 1'b0;
            total_next   = '0;
            flush_n_next = append ? (total_reg + CNT_W'(1)) : total_reg;
            idx_next     = '0;
            if (append || total_reg != '0) begin
                state_next = ST_FL_RD;
            end else begin
                state_next = ST_STATUS;
            end
        end

        // The forgotten entry is gone once the later entries have moved down.
        if (forget_fin) begin
            total_next = total_reg - CNT_W'(1);
            state_next = ST_STATUS;
            if (total_reg == CNT_W'(1)) begin
                run_next = 1'b0;
                cd_next  = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            total_reg   <= '0;
            cd_reg      <= '0;
            run_reg     <= 1'b0;
            delay_reg   <= DELAY_RESET;
            cmp_vld_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            total_reg   <= total_next;
            cd_reg      <= cd_next;
            run_reg     <= run_next;
            delay_reg   <= delay_next;
            cmp_vld_reg <= cmp_vld_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        act_reg     <= act_next;
        id_reg      <= id_next;
        idx_reg     <= idx_next;
        flush_n_reg <= flush_n_next;
        found_reg   <= found_next;
        ovf_reg     <= ovf_next;
        pend_reg    <= pend_next;
        sv_reg      <= sv_next;
        sid_reg     <= sid_next;
        last_reg    <= last_next;
        opend_reg   <= opend_next;
        ocnt_reg    <= ocnt_next;
        oovf_reg    <= oovf_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_synced_valid  = sv_reg;
    assign m_synced_id     = sid_reg;
    assign m_last          = last_reg;
    assign m_is_pending    = opend_reg;
    assign m_pending_count = ocnt_reg;
    assign m_overflow      = oovf_reg;

    // The pending count never exceeds the list depth.
    `DDSF_ASSERT_IMPL(a_total_bound, aclk, aresetn, 1'b1, total_reg <= CNT_W'(LIST_DEPTH))
    // A running countdown always has something to flush.
    `DDSF_ASSERT_IMPL(a_run_nonempty, aclk, aresetn, run_reg, total_reg != '0)
    // Words of a flush report an emptied list.
    `DDSF_ASSERT_IMPL(a_flush_word_empty, aclk, aresetn, m_valid && m_synced_valid,
                      m_pending_count == '0 && !m_is_pending)
    // An accepted event leaves the sequencer busy in the following cycle.
    `DDSF_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)

endmodule

>>> rtl/core/ddsf_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// Standalone; the depth and width come from its parameters.
module ddsf_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
